>>> design/tmar_pkg.sv
// ----------------------------------------------------------------------------
// tmar_pkg
// shared types and constants for the three-axis moving average report unit
// ----------------------------------------------------------------------------
package tmar_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int SAMPLE_W    = 12;
    localparam int INTERVAL_W  = 16;
    localparam int SCALE_W     = 12;
    localparam int MG_W        = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd1000;
    localparam logic [SCALE_W-1:0]    SCALE_RST    = 12'd512;

    localparam logic signed [MG_W-1:0] MG_MAX = 16'sh7fff;
    localparam logic signed [MG_W-1:0] MG_MIN = 16'sh8000;

    // configuration register indexes
    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_SCALE    = 1'b1;

    typedef struct packed {
        logic                       is_tick;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } t_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

>>> design/tmar_queue.sv
// ----------------------------------------------------------------------------
// tmar_queue
// front end: accepts input transactions, tags ticks and samples, short queue
// ----------------------------------------------------------------------------
module tmar_queue
    import tmar_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_action,
    input  logic signed [SAMPLE_W-1:0] i_sample_x,
    input  logic signed [SAMPLE_W-1:0] i_sample_y,
    input  logic signed [SAMPLE_W-1:0] i_sample_z,
    output logic                       o_head_valid,
    output t_item                      o_head,
    input  logic                       i_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item           r_store [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            push;
    logic            pop;
    t_item           item;

    assign o_stall      = (r_cnt == CW'(QUEUE_DEPTH));
    assign push         = i_valid && !o_stall;
    assign pop          = i_pop && o_head_valid;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_store[r_rp];

    always_comb begin
        item.is_tick = i_action;
        item.x       = i_sample_x;
        item.y       = i_sample_y;
        item.z       = i_sample_z;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_store[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> design/tmar_div.sv
// ----------------------------------------------------------------------------
// tmar_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tmar_div
    import tmar_pkg::*;
#(
    parameter int DVD_W = 22,
    parameter int DVS_W = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output t_div_status       o_status,
    output logic [DVD_W-1:0]  o_quot
);

    localparam int KW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [KW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             fits;

    assign rem_sh  = {r_rem, r_q[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign fits    = (rem_sh >= {1'b0, r_dvs});

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], fits};
            r_rem <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

endmodule

>>> design/tmar_engine.sv
// ----------------------------------------------------------------------------
// tmar_engine
// back end: ring store, running sums, tick count and report sequencing
// ----------------------------------------------------------------------------
module tmar_engine
    import tmar_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_head_valid,
    input  t_item                          i_head,
    output logic                           o_pop,
    input  logic [INTERVAL_W-1:0]          i_interval,
    input  logic [SCALE_W-1:0]             i_scale,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [MG_W-1:0]         o_x_mg,
    output logic signed [MG_W-1:0]         o_y_mg,
    output logic signed [MG_W-1:0]         o_z_mg,
    output logic [$clog2(DEPTH+1)-1:0]     o_window_fill
);

    localparam int AW     = $clog2(DEPTH);
    localparam int FW     = $clog2(DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + AW;
    localparam int PROD_W = SUM_W + SCALE_W + 1;
    localparam int NUM_W  = PROD_W + 2;
    localparam int DVD_W  = NUM_W - 9;
    localparam int ENT_W  = 3 * SAMPLE_W;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_UPD, S_CHECK, S_MUL, S_ABS, S_DIV, S_OUT
    } t_state;

    t_state                     r_state;
    t_item                      r_item;
    logic signed [SUM_W-1:0]    r_sum_x;
    logic signed [SUM_W-1:0]    r_sum_y;
    logic signed [SUM_W-1:0]    r_sum_z;
    logic [AW-1:0]              r_slot;
    logic [FW-1:0]              r_fill;
    logic [INTERVAL_W-1:0]      r_ticks;
    logic [1:0]                 r_axis;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_neg;
    logic signed [MG_W-1:0]     r_res [3];
    logic                       r_out_valid;
    logic signed [MG_W-1:0]     r_out_x;
    logic signed [MG_W-1:0]     r_out_y;
    logic signed [MG_W-1:0]     r_out_z;
    logic [FW-1:0]              r_out_fill;

    logic [ENT_W-1:0]           r_ring [DEPTH];
    logic [ENT_W-1:0]           r_rd;

    logic                       full;
    logic signed [SAMPLE_W-1:0] old_x;
    logic signed [SAMPLE_W-1:0] old_y;
    logic signed [SAMPLE_W-1:0] old_z;
    logic                       ring_we;
    logic signed [SUM_W-1:0]    sum_sel;
    logic signed [NUM_W-1:0]    num;
    logic [NUM_W-1:0]           num_mag;
    logic                       div_start;
    t_div_status                div_stat;
    logic [DVD_W-1:0]           quot;
    logic signed [MG_W-1:0]     res_sat;
    logic                       out_free;

    assign full    = (r_fill == FW'(DEPTH));
    assign old_x   = full ? r_rd[3*SAMPLE_W-1:2*SAMPLE_W] : '0;
    assign old_y   = full ? r_rd[2*SAMPLE_W-1:SAMPLE_W]   : '0;
    assign old_z   = full ? r_rd[SAMPLE_W-1:0]            : '0;
    assign ring_we = (r_state == S_UPD);

    // ring read is registered, the slot is read the cycle before the update
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_slot] <= {r_item.x, r_item.y, r_item.z};
        end
        r_rd <= r_ring[r_slot];
    end

    always_comb begin
        case (r_axis)
            AXIS_X:  sum_sel = r_sum_x;
            AXIS_Y:  sum_sel = r_sum_y;
            AXIS_Z:  sum_sel = r_sum_z;
            default: sum_sel = r_sum_x;
        endcase
    end

    // 2*sum*scale + 256*fill, magnitude then divided by 512 and the fill count
    assign num     = (NUM_W'(r_prod) <<< 1) + NUM_W'(signed'({1'b0, r_fill, 8'b0}));
    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    assign div_start = (r_state == S_ABS);

    tmar_div #(
        .DVD_W (DVD_W),
        .DVS_W (FW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num_mag[NUM_W-1:9]),
        .i_divisor  (r_fill),
        .o_status   (div_stat),
        .o_quot     (quot)
    );

    always_comb begin
        if (r_neg) begin
            if (quot > DVD_W'(32768)) begin
                res_sat = MG_MIN;
            end else begin
                res_sat = -signed'(quot[MG_W-1:0]);
            end
        end else begin
            if (quot > DVD_W'(32767)) begin
                res_sat = MG_MAX;
            end else begin
                res_sat = signed'(quot[MG_W-1:0]);
            end
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && i_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_ticks     <= '0;
            r_axis      <= AXIS_X;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_item <= i_head;
                        if (i_head.is_tick) begin
                            if (r_ticks != '1) begin
                                r_ticks <= r_ticks + 1'b1;
                            end
                            r_state <= S_CHECK;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    r_sum_x <= r_sum_x + SUM_W'(r_item.x) - SUM_W'(old_x);
                    r_sum_y <= r_sum_y + SUM_W'(r_item.y) - SUM_W'(old_y);
                    r_sum_z <= r_sum_z + SUM_W'(r_item.z) - SUM_W'(old_z);
                    r_slot  <= (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
                    if (!full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if ((r_ticks >= i_interval) && (r_fill != '0)) begin
                        r_axis  <= AXIS_X;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_prod  <= sum_sel * signed'({1'b0, i_scale});
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_neg   <= num[NUM_W-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_res[r_axis] <= res_sat;
                        if (r_axis == AXIS_Z) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_res[AXIS_X];
                        r_out_y     <= r_res[AXIS_Y];
                        r_out_z     <= r_res[AXIS_Z];
                        r_out_fill  <= r_fill;
                        r_ticks     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_x_mg        = r_out_x;
    assign o_y_mg        = r_out_y;
    assign o_z_mg        = r_out_z;
    assign o_window_fill = r_out_fill;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond window depth");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_report_clears_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_ticks == '0 && r_out_valid))
        else $error("report did not clear tick count");

    a_report_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_fill != '0))
        else $error("report with empty window");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_UPD || r_state == S_CHECK))
        else $error("dequeued transaction not taken up");

endmodule

>>> design/three_axis_moving_average_report_unit.sv
// a sample passes the engine states IDLE, UPD and CHECK, a tick IDLE and CHECK, after the queue
// a report then runs MUL, ABS and the serial divider for each axis in turn, then OUT
// the engine takes one transaction at a time and pops the next only when back in IDLE
// the single shared multiplier and one-bit-per-cycle divider run the three axes in turn
// synchronous active-low reset clears sums, counts and registers, no clearing pass
// ----------------------------------------------------------------------------
// three_axis_moving_average_report_unit
// boxcar moving average of three accelerometer axes with periodic reports
// ----------------------------------------------------------------------------
module three_axis_moving_average_report_unit
    import tmar_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_action,
    input  logic signed [SAMPLE_W-1:0]  i_sample_x,
    input  logic signed [SAMPLE_W-1:0]  i_sample_y,
    input  logic signed [SAMPLE_W-1:0]  i_sample_z,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [MG_W-1:0]      o_x_mg,
    output logic signed [MG_W-1:0]      o_y_mg,
    output logic signed [MG_W-1:0]      o_z_mg,
    output logic [$clog2(DEPTH+1)-1:0]  o_window_fill,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    logic [INTERVAL_W-1:0] r_interval;
    logic [SCALE_W-1:0]    r_scale;
    logic                  head_valid;
    t_item                 head;
    logic                  pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST;
            r_scale    <= SCALE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INTERVAL: r_interval <= i_cfg_data[INTERVAL_W-1:0];
                CFG_SCALE:    r_scale    <= i_cfg_data[SCALE_W-1:0];
                default:      r_scale    <= r_scale;
            endcase
        end
    end

    tmar_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_sample_x   (i_sample_x),
        .i_sample_y   (i_sample_y),
        .i_sample_z   (i_sample_z),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    tmar_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .i_interval    (r_interval),
        .i_scale       (r_scale),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_x_mg        (o_x_mg),
        .o_y_mg        (o_y_mg),
        .o_z_mg        (o_z_mg),
        .o_window_fill (o_window_fill)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the three-axis moving average report unit: random
// samples and millisecond ticks with idle gaps and output stalls, each report
// compared with a predicted boxcar average, scale and interval set per phase
// ----------------------------------------------------------------------------
module tb_top;
    import tmar_pkg::*;

    localparam int WIN          = DEPTH_DEF;
    localparam int FILL_W       = $clog2(WIN + 1);
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic signed [MG_W-1:0] x;
        logic signed [MG_W-1:0] y;
        logic signed [MG_W-1:0] z;
        logic [FILL_W-1:0]      fill;
    } t_mg_report;

    class report_board;
        int         ring_x[WIN];
        int         ring_y[WIN];
        int         ring_z[WIN];
        int         sum_x, sum_y, sum_z;
        int         slot, fill, ticks;
        int         interval, scale;
        int         mismatches;
        t_mg_report expected_reports[$];

        function new();
            interval = INTERVAL_RST;
            scale    = SCALE_RST;
        endfunction

        function void set_register(logic index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_INTERVAL) begin
                interval = data[INTERVAL_W-1:0];
            end else begin
                scale = data[SCALE_W-1:0];
            end
        endfunction

        function logic signed [MG_W-1:0] to_mg(int total);
            longint num, den, q;
            num = 2 * longint'(total) * scale + 256 * fill;
            den = 512 * fill;
            q   = num / den;
            if (q > MG_MAX) begin
                q = MG_MAX;
            end else if (q < MG_MIN) begin
                q = MG_MIN;
            end
            return q[MG_W-1:0];
        endfunction

        function void note_item(t_item it);
            t_mg_report r;
            int sx, sy, sz;
            if (!it.is_tick) begin
                sx = $signed(it.x);
                sy = $signed(it.y);
                sz = $signed(it.z);
                sum_x += sx - ring_x[slot];
                sum_y += sy - ring_y[slot];
                sum_z += sz - ring_z[slot];
                ring_x[slot] = sx;
                ring_y[slot] = sy;
                ring_z[slot] = sz;
                slot = (slot + 1) % WIN;
                if (fill < WIN) begin
                    fill++;
                end
            end else if (ticks < 16'hffff) begin
                ticks++;
            end
            if (ticks >= interval && fill > 0) begin
                r.x    = to_mg(sum_x);
                r.y    = to_mg(sum_y);
                r.z    = to_mg(sum_z);
                r.fill = fill[FILL_W-1:0];
                expected_reports.push_back(r);
                ticks = 0;
            end
        endfunction

        function void note_fault(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void check_report(logic signed [MG_W-1:0] x, logic signed [MG_W-1:0] y,
                                   logic signed [MG_W-1:0] z, logic [FILL_W-1:0] f);
            t_mg_report want;
            if (expected_reports.size() == 0) begin
                note_fault($sformatf("report with none pending: x=%0d y=%0d z=%0d fill=%0d",
                                     x, y, z, f));
                return;
            end
            want = expected_reports.pop_front();
            if (want.x !== x || want.y !== y || want.z !== z || want.fill !== f) begin
                note_fault($sformatf({"report mismatch: exp x=%0d y=%0d z=%0d fill=%0d",
                                      " got x=%0d y=%0d z=%0d fill=%0d"},
                                     $signed(want.x), $signed(want.y), $signed(want.z),
                                     want.fill, x, y, z, f));
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic                       i_action;
    logic signed [SAMPLE_W-1:0] i_sample_x;
    logic signed [SAMPLE_W-1:0] i_sample_y;
    logic signed [SAMPLE_W-1:0] i_sample_z;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [MG_W-1:0]     o_x_mg;
    logic signed [MG_W-1:0]     o_y_mg;
    logic signed [MG_W-1:0]     o_z_mg;
    logic [FILL_W-1:0]          o_window_fill;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic                       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    report_board board;
    bit          no_idle;

    three_axis_moving_average_report_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .i_sample_z    (i_sample_z),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_x_mg        (o_x_mg),
        .o_y_mg        (o_y_mg),
        .o_z_mg        (o_z_mg),
        .o_window_fill (o_window_fill),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 99) < 55) begin
            return 0;
        end
        return idle_length();
    endfunction

    function automatic logic [SAMPLE_W-1:0] axis_value();
        case ($urandom_range(0, 9))
            0: return 12'h7ff;
            1: return 12'h800;
            2: return 12'h000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic t_item make_sample(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y,
                                          logic [SAMPLE_W-1:0] z);
        t_item it;
        it.is_tick = 1'b0;
        it.x       = x;
        it.y       = y;
        it.z       = z;
        return it;
    endfunction

    function automatic t_item random_item(int tick_pct);
        t_item it;
        it = make_sample(axis_value(), axis_value(), axis_value());
        it.is_tick = ($urandom_range(0, 99) < tick_pct);
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= it.is_tick;
        i_sample_x <= it.x;
        i_sample_y <= it.y;
        i_sample_z <= it.z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_item(it);
    endtask

    task automatic write_register(input logic index, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_register(index, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] interval,
                             input logic [CFG_DATA_W-1:0] scale_data);
        write_register(CFG_INTERVAL, interval);
        write_register(CFG_SCALE, scale_data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (board.expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // report monitor and output stall generator
    initial begin
        int  run_left;
        bit  stalling;
        run_left = 0;
        stalling = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                board.check_report(o_x_mg, o_y_mg, o_z_mg, o_window_fill);
            end
            if (run_left == 0) begin
                stalling = ($urandom_range(0, 2) == 0);
                run_left = idle_length();
            end
            run_left--;
            i_stall <= stalling && !no_idle;
        end
    end

    initial begin
        int                    interval;
        logic [SCALE_W-1:0]    scale;
        board = new();
        no_idle = 1'b1;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_action    <= 1'b0;
        i_sample_x  <= '0;
        i_sample_y  <= '0;
        i_sample_z  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_INTERVAL;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset interval not reached, then empty window past the interval
        // so the first sample reports, reset scale in use
        repeat (20) send_item(random_item(100));
        wait_idle();
        write_register(CFG_INTERVAL, 16'd24);
        i_cfg_valid <= 1'b0;
        repeat (6) send_item(random_item(100));
        send_item(make_sample(12'h7ff, 12'h800, 12'h000));
        repeat (23) send_item(random_item(100));
        send_item(random_item(100));
        wait_idle();

        // interval zero, full scale: every transaction reports, window wraps
        no_idle = 1'b0;
        configure(16'h0000, 16'hffff);
        send_item(make_sample(12'h7ff, 12'h7ff, 12'h7ff));
        send_item(make_sample(12'h800, 12'h800, 12'h800));
        send_item(make_sample(12'h000, 12'hfff, 12'h001));
        send_item(make_sample(12'h555, 12'haaa, 12'h7ff));
        send_item(random_item(100));
        repeat (15) send_item(make_sample(12'h7ff, 12'h800, 12'haaa));
        wait_idle();

        // zero scale
        configure(16'h0001, 16'h0000);
        send_item(random_item(0));
        send_item(random_item(100));
        send_item(random_item(0));
        send_item(random_item(100));
        wait_idle();

        // longest interval
        no_idle = 1'b1;
        configure(16'hffff, 16'h0100);
        repeat (30) send_item(random_item(50));
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            case ($urandom_range(0, 9))
                0: interval = 0;
                1, 2, 3, 4, 5, 6: interval = $urandom_range(1, 6);
                default: interval = $urandom_range(10, 40);
            endcase
            case ($urandom_range(0, 5))
                0: scale = '0;
                1: scale = '1;
                default: scale = SCALE_W'($urandom_range(0, 4095));
            endcase
            no_idle = (p == 2);
            configure(interval[CFG_DATA_W-1:0], {4'($urandom), scale});
            repeat (135) send_item(random_item(50));
            wait_idle();
        end

        if (board.mismatches == 0 && board.expected_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
